/* sv/ted_pkg.sv */
package ted_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned ENTRIES_DEF   = 64;
  localparam int unsigned CODE_BITS_DEF = 16;

  // Fixed field widths
  localparam int unsigned CODE_W  = 16;
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned THR_W   = 7;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [THR_W-1:0]   THR_RST   = 7'd64;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW    = 2'd0,
    CFG_MAX_AGE   = 2'd1,
    CFG_THRESHOLD = 2'd2
  } cfg_reg_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE
  } ted_state_e;

  // Age compare direction of the shared unit
  typedef enum logic {
    AGE_ABOVE,   // bound < age
    AGE_BELOW    // age < bound
  } age_mode_e;

endpackage

/* sv/ted_ram.sv */
module ted_ram
  import ted_pkg::*;
#(
  parameter int unsigned DEPTH = ENTRIES_DEF,
  parameter int unsigned WIDTH = 1 + CODE_BITS_DEF + TIME_W + COUNT_W
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

/* sv/ted_age_unit.sv */
module ted_age_unit
  import ted_pkg::*;
(
  input  logic [TIME_W-1:0] now_i,
  input  logic [TIME_W-1:0] then_i,
  input  logic [TIME_W-1:0] bound_i,
  input  age_mode_e         mode_i,
  output logic              flag_o
);

  logic [TIME_W-1:0] age;
  logic [TIME_W-1:0] lhs;
  logic [TIME_W-1:0] rhs;

  // Age wraps modulo 2^64, then one magnitude compare against the bound
  assign age = now_i - then_i;
  assign lhs = (mode_i == AGE_ABOVE) ? bound_i : age;
  assign rhs = (mode_i == AGE_ABOVE) ? age : bound_i;
  assign flag_o = (lhs < rhs);

endmodule

/* sv/timed_event_dedup_table_top.sv */
// Channel   | Direction | Handshake               | Payload
// s_axis    | in        | s_axis_tvalid/tready    | tdata: code, now_time
// m_axis    | out       | m_axis_tvalid/tready    | tdata: repeat_count; tuser: verdict, full
// cfg       | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A result is registered after its input transaction, once a scan has made one read per
// row on the table's single read port, each read registered, and a resolve step has run.
// A new report is taken only in the idle state, so never while one is still in progress.
// After reset a clearing pass writes every row to zero before the first report
// is taken; configuration writes are taken in every cycle.
// A finished result waits in the output register; the next report is taken
// meanwhile and holds in resolve only while that register is still full.
module timed_event_dedup_table_top
  import ted_pkg::*;
#(
  parameter int unsigned ENTRIES   = ENTRIES_DEF,
  parameter int unsigned CODE_BITS = CODE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input reports
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [79:0]          s_axis_tdata,   // [15:0] code, [79:16] now_time
  // results
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata,   // [31:0] repeat_count
  output logic [1:0]           m_axis_tuser,   // [0] verdict, [1] table_full
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [TIME_W-1:0]    cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned OCC_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (OCC_W > THR_W) ? OCC_W : THR_W;
  localparam int unsigned ROW_W = 1 + CODE_BITS + TIME_W + COUNT_W;
  localparam logic [OCC_W-1:0] SCAN_END = OCC_W'(ENTRIES);
  localparam logic [OCC_W-1:0] CLR_LAST = OCC_W'(ENTRIES - 1);

  // Configuration registers
  logic [TIME_W-1:0] window_q, max_age_q;
  logic [THR_W-1:0]  thr_q;

  // Sequencer and scan control
  ted_state_e       state_q, state_d;
  logic [OCC_W-1:0] scan_q, scan_d;
  logic             eval_vld_q, eval_vld_d;
  logic [IDX_W-1:0] eval_idx_q;
  logic [OCC_W-1:0] occ_q, occ_d;
  logic             sweep_q, sweep_d;
  logic             hit_found_q, hit_found_d;
  logic             free_found_q, free_found_d;
  logic             out_vld_q, out_vld_d;

  // Per-report payload
  logic [CODE_BITS-1:0] code_q, code_in;
  logic [TIME_W-1:0]    now_q;
  logic [IDX_W-1:0]     hit_idx_q, free_idx_q;
  logic [TIME_W-1:0]    hit_time_q;
  logic [COUNT_W-1:0]   hit_count_q;
  logic                 verdict_q, full_q;
  logic [COUNT_W-1:0]   count_q;
  logic                 res_load;
  logic                 verdict_d, full_d;
  logic [COUNT_W-1:0]   count_d;

  // Memory ports
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic [ROW_W-1:0] wr_row, rd_row;

  // Row fields
  logic                 rd_valid;
  logic [CODE_BITS-1:0] rd_code;
  logic [TIME_W-1:0]    rd_time;
  logic [COUNT_W-1:0]   rd_count;

  // Shared age unit
  logic [TIME_W-1:0] age_then, age_bound;
  age_mode_e         age_mode;
  logic              age_flag;

  logic                 in_fire, out_free, issue, expired, eff_valid;
  logic [COUNT_W-1:0]   sat_count;

  assign rd_valid = rd_row[ROW_W-1];
  assign rd_code  = rd_row[ROW_W-2 -: CODE_BITS];
  assign rd_time  = rd_row[COUNT_W +: TIME_W];
  assign rd_count = rd_row[COUNT_W-1:0];

  // Code narrowed or widened to the stored width
  if (CODE_BITS <= CODE_W) begin : g_code_narrow
    assign code_in = s_axis_tdata[CODE_BITS-1:0];
  end else begin : g_code_wide
    assign code_in = {{(CODE_BITS-CODE_W){1'b0}}, s_axis_tdata[CODE_W-1:0]};
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign issue         = (scan_q != SCAN_END);
  assign rd_addr       = scan_q[IDX_W-1:0];

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q  <= '0;
      max_age_q <= '0;
      thr_q     <= THR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_WINDOW:    window_q  <= cfg_data_i;
        CFG_MAX_AGE:   max_age_q <= cfg_data_i;
        CFG_THRESHOLD: thr_q     <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Age unit operand select: per-row expiry while scanning, window at resolve
  assign age_mode  = (state_q == ST_RESOLVE) ? AGE_BELOW : AGE_ABOVE;
  assign age_then  = (state_q == ST_RESOLVE) ? hit_time_q : rd_time;
  assign age_bound = (state_q == ST_RESOLVE) ? window_q : max_age_q;

  ted_age_unit u_age (
    .now_i   (now_q),
    .then_i  (age_then),
    .bound_i (age_bound),
    .mode_i  (age_mode),
    .flag_o  (age_flag)
  );

  assign expired   = sweep_q && rd_valid && age_flag;
  assign eff_valid = rd_valid && !expired;
  assign sat_count = (hit_count_q == COUNT_MAX) ? hit_count_q : hit_count_q + COUNT_W'(1);

  // Sequencer: next state, memory writes and result
  always_comb begin
    state_d      = state_q;
    scan_d       = scan_q;
    eval_vld_d   = 1'b0;
    occ_d        = occ_q;
    sweep_d      = sweep_q;
    hit_found_d  = hit_found_q;
    free_found_d = free_found_q;
    out_vld_d    = out_vld_q && !m_axis_tready;
    wr_en        = 1'b0;
    wr_addr      = eval_idx_q;
    wr_row       = {1'b0, rd_row[ROW_W-2:0]};
    res_load     = 1'b0;
    verdict_d    = 1'b0;
    full_d       = 1'b0;
    count_d      = COUNT_W'(1);
    unique case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = scan_q[IDX_W-1:0];
        wr_row  = '0;
        scan_d  = scan_q + OCC_W'(1);
        if (scan_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_d      = ST_SCAN;
          scan_d       = '0;
          sweep_d      = (CMP_W'(occ_q) >= CMP_W'(thr_q));
          hit_found_d  = 1'b0;
          free_found_d = 1'b0;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          scan_d     = scan_q + OCC_W'(1);
          eval_vld_d = 1'b1;
        end
        if (eval_vld_q) begin
          if (expired) begin
            wr_en = 1'b1;
            occ_d = occ_q - OCC_W'(1);
          end
          if (eff_valid && (rd_code == code_q)) begin
            hit_found_d = 1'b1;
          end
          if (!eff_valid) begin
            free_found_d = 1'b1;
          end
        end else if (!issue) begin
          state_d = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (out_free) begin
          state_d   = ST_IDLE;
          res_load  = 1'b1;
          out_vld_d = 1'b1;
          if (hit_found_q) begin
            wr_en   = 1'b1;
            wr_addr = hit_idx_q;
            if (age_flag) begin
              verdict_d = 1'b1;
              count_d   = sat_count;
              wr_row    = {1'b1, code_q, hit_time_q, sat_count};
            end else begin
              wr_row    = {1'b1, code_q, now_q, COUNT_W'(1)};
            end
          end else if (free_found_q) begin
            wr_en   = 1'b1;
            wr_addr = free_idx_q;
            wr_row  = {1'b1, code_q, now_q, COUNT_W'(1)};
            occ_d   = occ_q + OCC_W'(1);
          end else begin
            full_d = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      scan_q       <= '0;
      eval_vld_q   <= 1'b0;
      occ_q        <= '0;
      sweep_q      <= 1'b0;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      scan_q       <= scan_d;
      eval_vld_q   <= eval_vld_d;
      occ_q        <= occ_d;
      sweep_q      <= sweep_d;
      hit_found_q  <= hit_found_d;
      free_found_q <= free_found_d;
      out_vld_q    <= out_vld_d;
    end
  end

  // Payload registers: report, first hit, first free slot, result
  always_ff @(posedge clk_i) begin
    eval_idx_q <= rd_addr;
    if (in_fire) begin
      code_q <= code_in;
      now_q  <= s_axis_tdata[CODE_W +: TIME_W];
    end
    if (state_q == ST_SCAN && eval_vld_q) begin
      if (!hit_found_q && eff_valid && (rd_code == code_q)) begin
        hit_idx_q   <= eval_idx_q;
        hit_time_q  <= rd_time;
        hit_count_q <= rd_count;
      end
      if (!free_found_q && !eff_valid) begin
        free_idx_q <= eval_idx_q;
      end
    end
    if (res_load) begin
      verdict_q <= verdict_d;
      full_q    <= full_d;
      count_q   <= count_d;
    end
  end

  ted_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (ROW_W)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_row),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_row)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = count_q;
  assign m_axis_tuser  = {full_q, verdict_q};

endmodule

/* sv/ted_checker.sv */
module ted_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [31:0]          m_axis_tdata,
  input logic [1:0]           m_axis_tuser
);

  // A report keeps the input side busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again right after a transaction");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Accepted reports always carry a count of one
  a_accept_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 32'd1)
    else $error("accepted report with count other than one");

  // Suppression means a stored hit: count at least two, never full
  a_suppress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      !m_axis_tuser[1] && m_axis_tdata != 32'd0 && m_axis_tdata != 32'd1)
    else $error("suppressed report with bad count or full flag");

endmodule

bind timed_event_dedup_table_top ted_checker u_ted_checker (.*);
